// File: sv/qmp_pkg.sv
// Shared types and constants for the quintic move profile block.
package qmp_pkg;

  // Angles are signed millidegrees.
  localparam int unsigned ANGLE_W = 20;
  typedef logic signed [ANGLE_W-1:0] angle_t;

  // Move duration in milliseconds, and elapsed control time.
  localparam int unsigned DUR_W = 30;
  localparam int unsigned ELAPSED_W = 32;
  typedef logic [DUR_W-1:0] duration_t;
  typedef logic [ELAPSED_W-1:0] elapsed_t;

  // Register widths.
  localparam int unsigned SPEED_W = 20;
  localparam int unsigned PERIOD_W = 14;

  // Configuration port.
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DATA_W = 20;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_SPEED = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAMPLE_PERIOD = 1'd1;
  localparam logic [SPEED_W-1:0] MAX_SPEED_RST = 20'd1000;
  localparam logic [PERIOD_W-1:0] SAMPLE_PERIOD_RST = 14'd200;

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_TICK = 1'b1;

  // Result codes.
  localparam logic MODE_STANDBY = 1'b0;
  localparam logic MODE_MOVING = 1'b1;
  localparam logic [1:0] RET_INIT = 2'd0;
  localparam logic [1:0] RET_RUNNING = 2'd1;
  localparam logic [1:0] RET_OK = 2'd2;
  localparam logic [6:0] ACTION_ACTIVE = 7'd90;
  localparam logic [6:0] ACTION_IDLE = 7'd0;

  // Kind of result an item produces.
  typedef logic [1:0] kind_t;
  localparam kind_t KIND_START = 2'd0;
  localparam kind_t KIND_MOVE = 2'd1;
  localparam kind_t KIND_END = 2'd2;

  // Step of the blend evaluation that the shared multiplier is working on.
  typedef logic [2:0] pw_t;
  localparam pw_t PW_S2 = 3'd0;
  localparam pw_t PW_S3 = 3'd1;
  localparam pw_t PW_S4 = 3'd2;
  localparam pw_t PW_S5 = 3'd3;
  localparam pw_t PW_OFF = 3'd4;

  // Arithmetic constants.
  localparam int unsigned Q_W = 17;            // Q1.16 value in 0..1.0
  localparam int unsigned RACC_W = 23;         // signed blend accumulator
  localparam int unsigned MUL_W = 38;          // product plus rounding term
  localparam logic [Q_W-1:0] ONE_Q16 = 17'h10000;
  localparam logic [MUL_W-1:0] ROUND_HALF = 38'h8000;
  localparam logic [DUR_W-1:0] MS_PER_S = 30'd1000;
  localparam logic signed [RACC_W-1:0] K_S3 = 23'sd10;
  localparam logic signed [RACC_W-1:0] K_S4 = 23'sd15;
  localparam logic signed [RACC_W-1:0] K_S5 = 23'sd6;

  // Step counts of the serial units.
  localparam logic [4:0] DUR_STEPS = 5'd30;   // quotient bits of the duration
  localparam logic [4:0] S_STEPS = 5'd17;     // quotient bits of s
  localparam logic [4:0] MUL_STEPS = 5'd9;    // radix-4 digits of a Q1.16 operand

  localparam int unsigned NUM_JOINT_PORTS = 4;

endpackage

// File: sv/quintic_move_profile.sv
// Top level of the quintic move profile: duration divider, blend evaluator and result register.
//
//   Channel  Direction  Handshake               Payload
//   cfg      in         cfg_valid / cfg_ready   cfg_index, cfg_data
//   in       in         in_valid / in_stall     in_req_type, in_target_tilt, in_start_q1..q4
//   out      out        out_valid / out_stall   out_pose_q1..q4, out_desired_q1, status
//
// A start item is accepted, scales the distance, and then runs the bit-serial divider
// that yields the duration one quotient bit per cycle, before the result register is loaded.
// A tick inside the move is accepted, runs the divider for s, then five passes of the
// radix-4 serial multiplier (a digit phase and a post step each) with a step to clamp the
// blend factor before the last pass, and then loads the result register.
// A tick after the move, or with zero duration, goes from acceptance straight to loading
// the result register.
// Reset is synchronous; the result register lets the next item in while it waits.
module quintic_move_profile #(
  parameter int unsigned JOINTS = 4
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qmp_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [qmp_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_req_type,
  input  qmp_pkg::angle_t                    in_target_tilt,
  input  qmp_pkg::angle_t                    in_start_q1,
  input  qmp_pkg::angle_t                    in_start_q2,
  input  qmp_pkg::angle_t                    in_start_q3,
  input  qmp_pkg::angle_t                    in_start_q4,
  output logic                               out_valid,
  input  logic                               out_stall,
  output qmp_pkg::angle_t                    out_pose_q1,
  output qmp_pkg::angle_t                    out_pose_q2,
  output qmp_pkg::angle_t                    out_pose_q3,
  output qmp_pkg::angle_t                    out_pose_q4,
  output qmp_pkg::angle_t                    out_desired_q1,
  output qmp_pkg::duration_t                 out_move_duration,
  output logic                               out_mode_status,
  output logic [1:0]                         out_action_ret,
  output logic [6:0]                         out_action_id,
  output logic                               out_done_res
);
  import qmp_pkg::*;

  // Sequencer states.
  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_SCALE = 3'd1;
  localparam logic [2:0] ST_DIV   = 3'd2;
  localparam logic [2:0] ST_MUL   = 3'd3;
  localparam logic [2:0] ST_POST  = 3'd4;
  localparam logic [2:0] ST_BLEND = 3'd5;
  localparam logic [2:0] ST_FIN   = 3'd6;

  // Control and architectural state.
  logic [2:0]           state_r;
  logic [4:0]           cnt_r;
  pw_t                  pw_r;
  kind_t                kind_r;
  logic                 out_valid_r;
  logic [SPEED_W-1:0]   speed_r;
  logic [PERIOD_W-1:0]  period_r;
  angle_t               init_r [JOINTS];
  angle_t               final_r;
  logic [ANGLE_W-1:0]   mag_r;
  logic                 neg_r;
  duration_t            duration_r;
  elapsed_t             elapsed_r;

  // Datapath registers.
  logic [DUR_W-1:0]     rem_r;
  logic [DUR_W-1:0]     dsr_r;
  logic [DUR_W-1:0]     div_r;
  logic [DUR_W-1:0]     q_r;
  logic [Q_W-1:0]       s_r;
  logic [MUL_W-1:0]     mc_r;
  logic [MUL_W-1:0]     mc3_r;
  logic [Q_W:0]         mb_r;
  logic [MUL_W-1:0]     acc_r;
  logic signed [RACC_W-1:0] racc_r;
  angle_t               pose1_r;

  // Result register.
  angle_t               out_pose_r [NUM_JOINT_PORTS];
  angle_t               out_desired_r;
  duration_t            out_duration_r;
  logic                 out_mode_r;
  logic [1:0]           out_ret_r;
  logic [6:0]           out_id_r;
  logic                 out_done_r;

  // Combinational helpers.
  logic                 in_fire;
  logic                 cfg_fire;
  logic                 out_free;
  logic                 last_step;
  logic                 tick_active;
  logic [ELAPSED_W:0]   elapsed_sum;
  elapsed_t             elapsed_next;
  logic signed [ANGLE_W:0] in_diff;
  logic [ANGLE_W:0]     in_mag;
  logic [DUR_W-1:0]     scaled_dist;
  logic [DUR_W-1:0]     speed_div;
  logic [DUR_W:0]       div_trial;
  logic [DUR_W:0]       div_dif;
  logic                 div_ge;
  logic [DUR_W-1:0]     rem_step;
  logic [DUR_W-1:0]     q_step;
  logic [MUL_W-1:0]     pp;
  logic [Q_W-1:0]       pow_res;
  logic [ANGLE_W-1:0]   off_res;
  logic signed [RACC_W-1:0] pow_sx;
  logic [Q_W-1:0]       r_clamp;
  logic [ANGLE_W:0]     pose_sum;
  logic                 mul_load;
  logic [ANGLE_W-1:0]   mul_a;
  logic [Q_W-1:0]       mul_b;
  angle_t               in_q [NUM_JOINT_PORTS];
  angle_t               held [NUM_JOINT_PORTS];

  // Handshakes.
  assign in_fire   = in_valid && !in_stall;
  assign in_stall  = (state_r != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign out_free  = !out_valid_r || !out_stall;
  assign last_step = (cnt_r == 5'd1);

  // Start angles as an array, and the latched angles padded with zero beyond JOINTS.
  assign in_q[0] = in_start_q1;
  assign in_q[1] = in_start_q2;
  assign in_q[2] = in_start_q3;
  assign in_q[3] = in_start_q4;

  for (genvar g = 0; g < NUM_JOINT_PORTS; g++) begin : g_held
    if (g < JOINTS) begin : g_on
      assign held[g] = init_r[g];
    end else begin : g_off
      assign held[g] = '0;
    end
  end

  // Distance of joint one on a start transfer.
  assign in_diff = {in_target_tilt[ANGLE_W-1], in_target_tilt}
                 - {in_start_q1[ANGLE_W-1], in_start_q1};
  assign in_mag  = in_diff[ANGLE_W] ? (ANGLE_W + 1)'(1) + ~in_diff : in_diff;

  // Elapsed time advance with saturation.
  assign tick_active  = (elapsed_r <= {2'b00, duration_r});
  assign elapsed_sum  = {1'b0, elapsed_r} + {{(ELAPSED_W + 1 - PERIOD_W){1'b0}}, period_r};
  assign elapsed_next = elapsed_sum[ELAPSED_W] ? '1 : elapsed_sum[ELAPSED_W-1:0];

  // Dividend and divisor of the duration division.
  assign scaled_dist = DUR_W'(mag_r) * MS_PER_S;
  assign speed_div   = (speed_r == '0) ? DUR_W'(1) : DUR_W'(speed_r);

  // One restoring division step.
  assign div_trial = {rem_r, dsr_r[DUR_W-1]};
  assign div_dif   = div_trial - {1'b0, div_r};
  assign div_ge    = (div_trial >= {1'b0, div_r});
  assign rem_step  = div_ge ? div_dif[DUR_W-1:0] : div_trial[DUR_W-1:0];
  assign q_step    = {q_r[DUR_W-2:0], div_ge};

  // Partial product of one radix-4 multiplier digit.
  always_comb begin
    case (mb_r[1:0])
      2'd0:    pp = '0;
      2'd1:    pp = mc_r;
      2'd2:    pp = {mc_r[MUL_W-2:0], 1'b0};
      default: pp = mc3_r;
    endcase
  end

  // Rounded products; the half-LSB term is preloaded into the accumulator.
  assign pow_res = acc_r[Q_W+15:16];
  assign off_res = acc_r[ANGLE_W+15:16];
  assign pow_sx  = $signed({{(RACC_W - Q_W){1'b0}}, pow_res});

  // Blend factor clamped to 0..1.0.
  always_comb begin
    if (racc_r < 0) begin
      r_clamp = '0;
    end else if (racc_r > $signed({{(RACC_W - Q_W){1'b0}}, ONE_Q16})) begin
      r_clamp = ONE_Q16;
    end else begin
      r_clamp = racc_r[Q_W-1:0];
    end
  end

  // Joint one offset applied with the sign of the move.
  assign pose_sum = neg_r ? {init_r[0][ANGLE_W-1], init_r[0]} - {1'b0, off_res}
                          : {init_r[0][ANGLE_W-1], init_r[0]} + {1'b0, off_res};

  // Operand selection for loading the serial multiplier.
  always_comb begin
    mul_load = 1'b0;
    mul_a    = '0;
    mul_b    = '0;
    unique case (state_r)
      ST_DIV: begin
        if (last_step && kind_r != KIND_START) begin
          mul_load = 1'b1;
          mul_a    = ANGLE_W'(q_step[Q_W-1:0]);
          mul_b    = q_step[Q_W-1:0];
        end
      end
      ST_POST: begin
        if (pw_r != PW_S5 && pw_r != PW_OFF) begin
          mul_load = 1'b1;
          mul_a    = ANGLE_W'(pow_res);
          mul_b    = s_r;
        end
      end
      ST_BLEND: begin
        mul_load = 1'b1;
        mul_a    = mag_r;
        mul_b    = r_clamp;
      end
      default: begin
        mul_load = 1'b0;
      end
    endcase
  end

  // Sequencer, registers and latched move state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      pw_r        <= PW_S2;
      kind_r      <= KIND_START;
      out_valid_r <= 1'b0;
      speed_r     <= MAX_SPEED_RST;
      period_r    <= SAMPLE_PERIOD_RST;
      for (int j = 0; j < JOINTS; j++) init_r[j] <= '0;
      final_r     <= '0;
      mag_r       <= '0;
      neg_r       <= 1'b0;
      duration_r  <= '0;
      elapsed_r   <= '0;
    end else begin
      out_valid_r <= (state_r == ST_FIN && out_free) || (out_valid_r && out_stall);

      if (cfg_fire) begin
        unique case (cfg_index)
          REG_MAX_SPEED:     speed_r  <= cfg_data[SPEED_W-1:0];
          REG_SAMPLE_PERIOD: period_r <= cfg_data[PERIOD_W-1:0];
        endcase
      end

      unique case (state_r)
        ST_IDLE: begin
          if (in_fire) begin
            if (in_req_type == REQ_START) begin
              for (int j = 0; j < JOINTS; j++) init_r[j] <= in_q[j];
              final_r   <= in_target_tilt;
              mag_r     <= in_mag[ANGLE_W-1:0];
              neg_r     <= in_diff[ANGLE_W];
              elapsed_r <= '0;
              kind_r    <= KIND_START;
              state_r   <= ST_SCALE;
            end else begin
              elapsed_r <= elapsed_next;
              if (!tick_active) begin
                kind_r  <= KIND_END;
                state_r <= ST_FIN;
              end else if (duration_r == '0) begin
                kind_r  <= KIND_MOVE;
                state_r <= ST_FIN;
              end else begin
                kind_r  <= KIND_MOVE;
                cnt_r   <= S_STEPS;
                state_r <= ST_DIV;
              end
            end
          end
        end
        ST_SCALE: begin
          cnt_r   <= DUR_STEPS;
          state_r <= ST_DIV;
        end
        ST_DIV: begin
          if (last_step) begin
            if (kind_r == KIND_START) begin
              duration_r <= q_step;
              cnt_r      <= '0;
              state_r    <= ST_FIN;
            end else begin
              pw_r    <= PW_S2;
              cnt_r   <= MUL_STEPS;
              state_r <= ST_MUL;
            end
          end else begin
            cnt_r <= cnt_r - 5'd1;
          end
        end
        ST_MUL: begin
          cnt_r <= cnt_r - 5'd1;
          if (last_step) begin
            state_r <= ST_POST;
          end
        end
        ST_POST: begin
          if (pw_r == PW_OFF) begin
            state_r <= ST_FIN;
          end else if (pw_r == PW_S5) begin
            state_r <= ST_BLEND;
          end else begin
            pw_r    <= pw_r + 3'd1;
            cnt_r   <= MUL_STEPS;
            state_r <= ST_MUL;
          end
        end
        ST_BLEND: begin
          pw_r    <= PW_OFF;
          cnt_r   <= MUL_STEPS;
          state_r <= ST_MUL;
        end
        ST_FIN: begin
          if (out_free) begin
            state_r <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  // Divider, multiplier, blend accumulator and result register.
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          if (in_req_type == REQ_START) begin
            pose1_r <= in_start_q1;
          end else if (!tick_active || duration_r == '0) begin
            pose1_r <= final_r;
          end else begin
            // First step sees the whole elapsed time; later steps shift in zeros.
            rem_r <= {1'b0, elapsed_r[DUR_W-1:1]};
            dsr_r <= {elapsed_r[0], {(DUR_W - 1){1'b0}}};
            div_r <= duration_r;
            q_r   <= '0;
          end
        end
      end
      ST_SCALE: begin
        rem_r <= '0;
        dsr_r <= scaled_dist;
        div_r <= speed_div;
        q_r   <= '0;
      end
      ST_DIV: begin
        rem_r <= rem_step;
        dsr_r <= {dsr_r[DUR_W-2:0], 1'b0};
        q_r   <= q_step;
        if (last_step && kind_r != KIND_START) begin
          s_r <= q_step[Q_W-1:0];
        end
      end
      ST_MUL: begin
        acc_r <= acc_r + pp;
        mc_r  <= {mc_r[MUL_W-3:0], 2'b00};
        mc3_r <= {mc3_r[MUL_W-3:0], 2'b00};
        mb_r  <= {2'b00, mb_r[Q_W:2]};
      end
      ST_POST: begin
        case (pw_r)
          PW_S3:   racc_r <= pow_sx * K_S3;
          PW_S4:   racc_r <= racc_r - pow_sx * K_S4;
          PW_S5:   racc_r <= racc_r + pow_sx * K_S5;
          PW_OFF:  pose1_r <= pose_sum[ANGLE_W-1:0];
          default: racc_r <= racc_r;
        endcase
      end
      ST_FIN: begin
        if (out_free) begin
          out_pose_r[0]  <= pose1_r;
          for (int j = 1; j < NUM_JOINT_PORTS; j++) out_pose_r[j] <= held[j];
          out_desired_r  <= final_r;
          out_duration_r <= duration_r;
          out_mode_r     <= (kind_r == KIND_END) ? MODE_STANDBY : MODE_MOVING;
          out_id_r       <= (kind_r == KIND_END) ? ACTION_IDLE : ACTION_ACTIVE;
          out_done_r     <= (kind_r == KIND_END);
          unique case (kind_r)
            KIND_START: out_ret_r <= RET_INIT;
            KIND_MOVE:  out_ret_r <= RET_RUNNING;
            default:    out_ret_r <= RET_OK;
          endcase
        end
      end
      default: begin
      end
    endcase

    // Load the multiplier with the rounding term preset.
    if (mul_load) begin
      mc_r  <= MUL_W'(mul_a);
      mc3_r <= MUL_W'(mul_a) + (MUL_W'(mul_a) << 1);
      mb_r  <= {1'b0, mul_b};
      acc_r <= ROUND_HALF;
    end
  end

  // Ports.
  assign out_valid         = out_valid_r;
  assign out_pose_q1       = out_pose_r[0];
  assign out_pose_q2       = out_pose_r[1];
  assign out_pose_q3       = out_pose_r[2];
  assign out_pose_q4       = out_pose_r[3];
  assign out_desired_q1    = out_desired_r;
  assign out_move_duration = out_duration_r;
  assign out_mode_status   = out_mode_r;
  assign out_action_ret    = out_ret_r;
  assign out_action_id     = out_id_r;
  assign out_done_res      = out_done_r;

`ifndef SYNTHESIS
  // An accepted item always takes the sequencer out of idle.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r != ST_IDLE))
    else $error("sequencer idle right after an accepted transfer");

  // The divider remainder stays below the divisor throughout the division.
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV) |-> (rem_r < div_r))
    else $error("divider remainder reached the divisor");

  // Every rounded power of s stays within 0..1.0.
  a_pow_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_POST && pw_r != PW_OFF) |-> (acc_r[MUL_W-1:16] <= 22'd65536))
    else $error("power of s above one");

  // A finished move reports the target in standby.
  a_done_target: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_done_res) |->
      (out_pose_q1 == out_desired_q1 && out_mode_status == MODE_STANDBY))
    else $error("done result without target pose");
`endif

endmodule
